// ===== hw/rtl/wst_pkg.sv =====
// ----------------------------------------------------------------------------
// wst_pkg
// Shared constants, codes and controller/datapath link types for the
// WAV stream trimmer.
// ----------------------------------------------------------------------------
package wst_pkg;

  // Width of the size fields kept from the header (16..32)
  localparam int SIZE_BITS  = 32;
  localparam int WORD_BITS  = 32;

  localparam int BYTE_W     = 8;
  localparam int TB_W       = 24;
  localparam int TE_W       = 24;
  localparam int CFB_W      = 8;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int POS_W      = 6;
  localparam int HALF_W     = 16;
  localparam int CNT_W      = 32;

  localparam int FRAMES_W   = TB_W + 1;
  localparam int PROD_W     = 2 * HALF_W;
  localparam int BPF_W      = PROD_W - 3;
  localparam int LO_W       = 16;
  localparam int FR_HI_W    = FRAMES_W - LO_W;
  localparam int TB_HI_W    = TB_W - LO_W;
  localparam int DEC_W      = BPF_W + FRAMES_W;
  localparam int SKIP_W     = BPF_W + TB_W;
  localparam int RPROD_W    = CFB_W + FRAMES_W;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_BEGIN        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_END          = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_FRAME_BYTES = 2'd2;

  localparam logic [CFB_W-1:0] CFB_RESET = 8'd2;

  // Header byte positions of interest
  localparam logic [POS_W-1:0] POS_RIFF_FIRST  = 6'd4;
  localparam logic [POS_W-1:0] POS_RIFF_LAST   = 6'd7;
  localparam logic [POS_W-1:0] POS_CH_LAST     = 6'd23;
  localparam logic [POS_W-1:0] POS_SB_LAST     = 6'd35;
  localparam logic [POS_W-1:0] POS_DSIZE_FIRST = 6'd40;
  localparam logic [POS_W-1:0] POS_DSIZE_LAST  = 6'd43;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_SKIP   = 4'b0010,
    PH_COPY   = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // input item taken this cycle
    logic riff;       // form new RIFF size word
    logic bpf;        // bytes per frame
    logic mul_lo;     // low partial products
    logic mul_hi;     // high partial products
    logic sum;        // combine partial products
    logic dsize;      // form new data size word, load counters
    logic word_step;  // push next word byte into output register
  } wst_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic evt_riff;
    logic evt_dsize;
    logic word_last;
  } wst_sts_t;

endpackage

// ===== hw/rtl/wst_in_if.sv =====
// ----------------------------------------------------------------------------
// wst_in_if
// Input byte channel: valid/ready with byte and file start mark.
// ----------------------------------------------------------------------------
interface wst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       file_start;

  modport source (output valid, output in_byte, output file_start, input ready);
  modport sink   (input valid, input in_byte, input file_start, output ready);
endinterface

// ===== hw/rtl/wst_out_if.sv =====
// ----------------------------------------------------------------------------
// wst_out_if
// Output byte channel: valid/ready with byte, run end and status.
// ----------------------------------------------------------------------------
interface wst_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       status;

  modport source (output valid, output out_byte, output run_end, output status,
                  input ready);
  modport sink   (input valid, input out_byte, input run_end, input status,
                  output ready);
endinterface

// ===== hw/rtl/wav_stream_trimmer.sv =====
// ----------------------------------------------------------------------------
// wav_stream_trimmer
// Parses a canonical 44-byte WAV header, rewrites the RIFF and data sizes
// for the trimmed length, and drops leading and trailing sample frames.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake          payload
//  -------   ---   ---------          -------
//  in_ch     in    valid/ready        in_byte[7:0], file_start
//  out_ch    out   valid/ready        out_byte[7:0], run_end, status
//  cfg       in    cfg_we (no wait)   cfg_index[1:0], cfg_data[23:0]
//
//  Cycles: one byte per cycle for echoed, skipped and copied bytes while out_ch is not stalled.
//  The last RIFF size byte is followed by a subtract step and four output
//  bytes; the last data size byte is followed by the shared multiply
//  sequence (bytes per frame, two partial product steps, sum, clamp) and
//  four output bytes, during which in_ch.ready is low.
//  Reset: synchronous, active high; trims clear, chunk frame bytes to 2.
//  Stalls: out_ch.ready low holds the output register; input is taken only
//  while that register is empty or being emptied.
//
module wav_stream_trimmer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [wst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wst_pkg::CFG_DATA_W-1:0]    cfg_data,
  wst_in_if.sink                            in_ch,
  wst_out_if.source                         out_ch
);
  import wst_pkg::*;

  wst_cmd_t cmd;
  wst_sts_t sts;
  logic     in_ready;
  logic     out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic     run_end;
  logic     status;

  // Sequencer: owns the input handshake and the multi-cycle size steps
  wst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: header fields, counters, arithmetic and output register
  wst_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_byte    (in_ch.in_byte),
    .file_start (in_ch.file_start),
    .out_ready  (out_ch.ready),
    .out_valid  (out_valid),
    .out_byte   (out_byte),
    .run_end    (run_end),
    .status     (status),
    .cmd        (cmd),
    .sts        (sts)
  );

  assign in_ch.ready     = in_ready;
  assign out_ch.valid    = out_valid;
  assign out_ch.out_byte = out_byte;
  assign out_ch.run_end  = run_end;
  assign out_ch.status   = status;

endmodule

// ===== hw/rtl/wst_ctrl.sv =====
// ----------------------------------------------------------------------------
// wst_ctrl
// Sequencer: byte intake, size arithmetic steps and four-byte word output.
// ----------------------------------------------------------------------------
module wst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  wst_pkg::wst_sts_t sts,
  output wst_pkg::wst_cmd_t cmd
);
  import wst_pkg::*;

  typedef enum logic [7:0] {
    ST_RUN    = 8'b0000_0001,
    ST_RIFF   = 8'b0000_0010,
    ST_BPF    = 8'b0000_0100,
    ST_MUL_LO = 8'b0000_1000,
    ST_MUL_HI = 8'b0001_0000,
    ST_SUM    = 8'b0010_0000,
    ST_DSIZE  = 8'b0100_0000,
    ST_WORD   = 8'b1000_0000
  } ctrl_state_t;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_RUN: begin
        in_ready   = sts.out_free;
        cmd.accept = in_valid && sts.out_free;
        if (cmd.accept && sts.evt_riff) begin
          state_next = ST_RIFF;
        end else if (cmd.accept && sts.evt_dsize) begin
          state_next = ST_BPF;
        end
      end
      ST_RIFF: begin
        cmd.riff   = 1'b1;
        state_next = ST_WORD;
      end
      ST_BPF: begin
        cmd.bpf    = 1'b1;
        state_next = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_DSIZE;
      end
      ST_DSIZE: begin
        cmd.dsize  = 1'b1;
        state_next = ST_WORD;
      end
      ST_WORD: begin
        if (sts.out_free) begin
          cmd.word_step = 1'b1;
          if (sts.word_last) begin
            state_next = ST_RUN;
          end
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

endmodule

// ===== hw/rtl/wst_dpath.sv =====
// ----------------------------------------------------------------------------
// wst_dpath
// Header field capture, size arithmetic, skip/copy counters, output register.
// ----------------------------------------------------------------------------
module wst_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [wst_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wst_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [wst_pkg::BYTE_W-1:0]          in_byte,
  input  logic                                file_start,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [wst_pkg::BYTE_W-1:0]          out_byte,
  output logic                                run_end,
  output logic                                status,
  input  wst_pkg::wst_cmd_t                   cmd,
  output wst_pkg::wst_sts_t                   sts
);
  import wst_pkg::*;

  // configuration
  logic [TB_W-1:0]  trim_begin;
  logic [TE_W-1:0]  trim_end;
  logic [CFB_W-1:0] chunk_frame_bytes;

  // parse state
  phase_t             phase;
  logic [POS_W-1:0]   pos;
  logic [WORD_BITS-1:0] acc;
  logic [CNT_W-1:0]   skip_rem;
  logic [CNT_W-1:0]   copy_rem;
  logic [1:0]         wcnt;

  // captured fields and arithmetic
  logic [SIZE_BITS-1:0] riff_size;
  logic [SIZE_BITS-1:0] dsize;
  logic [HALF_W-1:0]    channel_count;
  logic [HALF_W-1:0]    sample_bits;
  logic [FRAMES_W-1:0]  frames;
  logic [RPROD_W-1:0]   riff_prod;
  logic [BPF_W-1:0]     bpf;
  logic [BPF_W+LO_W-1:0]    p_lo;
  logic [BPF_W+FR_HI_W-1:0] p_hi;
  logic [BPF_W+LO_W-1:0]    q_lo;
  logic [BPF_W+TB_HI_W-1:0] q_hi;
  logic [DEC_W-1:0]     dec;
  logic [SKIP_W-1:0]    skip_full;
  logic [WORD_BITS-1:0] word;
  logic                 flag;

  // combinational
  phase_t               phase_eff;
  logic [POS_W-1:0]     pos_eff;
  logic [WORD_BITS-1:0] acc_eff;
  logic [WORD_BITS-1:0] acc_next;
  logic                 is_hdr;
  logic                 hdr_last;
  logic                 hdr_quiet;
  logic                 in_skip;
  logic                 copy_go;
  logic                 emit_byte;
  logic [SIZE_BITS-1:0] riff_new;
  logic                 under;
  logic [SIZE_BITS-1:0] dsize_new;
  logic [CNT_W-1:0]     skip_sat;
  logic [PROD_W-1:0]    ch_sb;

  always_comb begin
    phase_eff = file_start ? PH_HEADER : phase;
    pos_eff   = file_start ? '0 : pos;
    acc_eff   = file_start ? '0 : acc;
    acc_next  = {in_byte, acc_eff[WORD_BITS-1:BYTE_W]};
    is_hdr    = (phase_eff == PH_HEADER);
    hdr_last  = (pos_eff >= POS_DSIZE_LAST);
    hdr_quiet = (pos_eff inside {[POS_RIFF_FIRST:POS_RIFF_LAST],
                                 [POS_DSIZE_FIRST:POS_DSIZE_LAST]});
    in_skip   = (phase_eff == PH_SKIP) && (skip_rem != '0);
    copy_go   = (phase_eff == PH_COPY) || ((phase_eff == PH_SKIP) && (skip_rem == '0));
    emit_byte = (is_hdr && !hdr_quiet) || (copy_go && (copy_rem != '0));

    riff_new  = riff_size - riff_prod[SIZE_BITS-1:0];
    under     = dec > DEC_W'(dsize);
    dsize_new = under ? '0 : dsize - dec[SIZE_BITS-1:0];
    skip_sat  = (skip_full[SKIP_W-1:CNT_W] != '0) ? '1 : skip_full[CNT_W-1:0];
    ch_sb     = channel_count * sample_bits;

    sts.out_free  = !out_valid || out_ready;
    sts.evt_riff  = is_hdr && (pos_eff == POS_RIFF_LAST);
    sts.evt_dsize = is_hdr && hdr_last;
    sts.word_last = (wcnt == 2'd3);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      trim_begin        <= '0;
      trim_end          <= '0;
      chunk_frame_bytes <= CFB_RESET;
      phase             <= PH_HEADER;
      pos               <= '0;
      acc               <= '0;
      skip_rem          <= '0;
      copy_rem          <= '0;
      wcnt              <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TRIM_BEGIN:        trim_begin        <= cfg_data[TB_W-1:0];
          REG_TRIM_END:          trim_end          <= cfg_data[TE_W-1:0];
          REG_CHUNK_FRAME_BYTES: chunk_frame_bytes <= cfg_data[CFB_W-1:0];
          default: ;
        endcase
      end

      if (cmd.accept) begin
        if (is_hdr) begin
          acc <= acc_next;
          if (hdr_last) begin
            pos   <= '0;
            phase <= PH_SKIP;
          end else begin
            pos   <= pos_eff + 1'b1;
            phase <= PH_HEADER;
          end
        end else if (in_skip) begin
          skip_rem <= skip_rem - 1'b1;
        end else if (copy_go) begin
          if (copy_rem != '0) begin
            copy_rem <= copy_rem - 1'b1;
            phase    <= (copy_rem == CNT_W'(1)) ? PH_DONE : PH_COPY;
          end else begin
            phase <= PH_DONE;
          end
        end
      end

      if (cmd.dsize) begin
        skip_rem <= skip_sat;
        copy_rem <= CNT_W'(dsize_new);
      end

      if (cmd.riff || cmd.dsize) begin
        wcnt <= '0;
      end else if (cmd.word_step) begin
        wcnt <= wcnt + 1'b1;
      end

      if ((cmd.accept && emit_byte) || cmd.word_step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    frames    <= FRAMES_W'(trim_begin) + FRAMES_W'(trim_end);
    riff_prod <= chunk_frame_bytes * (FRAMES_W'(trim_begin) + FRAMES_W'(trim_end));

    if (cmd.accept && is_hdr) begin
      if (pos_eff == POS_RIFF_LAST) riff_size     <= acc_next[SIZE_BITS-1:0];
      if (pos_eff == POS_CH_LAST)   channel_count <= acc_next[WORD_BITS-1:HALF_W];
      if (pos_eff == POS_SB_LAST)   sample_bits   <= acc_next[WORD_BITS-1:HALF_W];
      if (hdr_last)                 dsize         <= acc_next[SIZE_BITS-1:0];
    end

    if (cmd.bpf) begin
      bpf <= ch_sb[PROD_W-1:3];
    end
    if (cmd.mul_lo) begin
      p_lo <= bpf * frames[LO_W-1:0];
      q_lo <= bpf * trim_begin[LO_W-1:0];
    end
    if (cmd.mul_hi) begin
      p_hi <= bpf * frames[FRAMES_W-1:LO_W];
      q_hi <= bpf * trim_begin[TB_W-1:LO_W];
    end
    if (cmd.sum) begin
      dec       <= DEC_W'(p_lo) + {p_hi, {LO_W{1'b0}}};
      skip_full <= SKIP_W'(q_lo) + {q_hi, {LO_W{1'b0}}};
    end

    if (cmd.riff) begin
      word <= WORD_BITS'(riff_new);
      flag <= 1'b0;
    end else if (cmd.dsize) begin
      word <= WORD_BITS'(dsize_new);
      flag <= under;
    end else if (cmd.word_step) begin
      word <= word >> BYTE_W;
    end

    if (cmd.accept && emit_byte) begin
      out_byte <= in_byte;
      run_end  <= 1'b1;
      status   <= 1'b0;
    end else if (cmd.word_step) begin
      out_byte <= word[BYTE_W-1:0];
      run_end  <= sts.word_last;
      status   <= flag;
    end
  end

endmodule

// ===== hw/rtl/wst_checker.sv =====
// ----------------------------------------------------------------------------
// wst_checker
// Port-level checks for the WAV stream trimmer, bound to the top level.
// ----------------------------------------------------------------------------
module wst_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_end,
  input logic       status
);

  // output register empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // stalled item holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
                                $stable(run_end) && $stable(status))
    else $error("stalled output item changed");

  // no new input while a size word is part way out
  a_word_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !run_end |-> !(in_valid && in_ready))
    else $error("input taken during size word");

  // clamped data size is zero
  a_clamp_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> out_byte == 8'd0)
    else $error("clamped size byte not zero");

endmodule

bind wav_stream_trimmer wst_checker u_wst_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .run_end   (out_ch.run_end),
  .status    (out_ch.status)
);
